FILE: src/csort_pkg.sv
// Package for the comb sort engine: command and status types between
// controller and datapath, and the fixed constants of the gap rule.
// No dependencies.
`default_nettype none
package csort_pkg;

	localparam int VALUE_BITS = 16;
	localparam int GAP_MUL    = 10;
	localparam int GAP_DEN    = 13;
	localparam int GAP_SKIP_LO = 9;
	localparam int GAP_SKIP_HI = 10;
	localparam int GAP_ELEVEN  = 11;

	typedef struct packed {
		logic load;
		logic init_sort;
		logic begin_pass;
		logic rd_pair;
		logic write_i;
		logic write_j;
		logic idx_inc;
		logic rd_out;
		logic out_load;
	} csort_cmd_t;

	typedef struct packed {
		logic gap_gt1;
		logic swap;
		logic pair_ok;
		logic greater;
		logic out_free;
		logic out_last;
	} csort_sts_t;

endpackage
`default_nettype wire

FILE: src/comb_sort_engine_unit.sv
// Channel    Dir  Bits  Payload
// s_axis     in   16+1  tdata: value[15:0]; tlast: last
// m_axis     out  16+1  tdata: sorted_value[15:0]; tlast: last_out
// cfg        in   1     data: signed_compare
// Loading accepts one request per cycle; a request beyond MAX_ITEMS is dropped.
// Sorting: a start step, then a pass start and an end-of-pass test per pass;
// each pair is read and compared; a swap writes both, through one write port.
// Output: each result is read from memory, then loaded into the output register.
// A result waiting in the output register stalls only the output sequencer.
// Reset clears count, gap and mode, sets the swap flag; element memory is not reset.
// Depends on csort_pkg, csort_ctrl and csort_dp.
`default_nettype none
module comb_sort_engine_unit import csort_pkg::*; #(
	parameter int MAX_ITEMS    = 64,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [VALUE_BITS-1:0] s_axis_tdata,  // value[15:0]
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [VALUE_BITS-1:0]      m_axis_tdata,  // sorted_value[15:0]
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data
);

	csort_cmd_t cmd;
	csort_sts_t sts;

	assign cfg_ready = 1'b1;

	csort_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csort_dp #(
		.MAX_ITEMS    (MAX_ITEMS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (s_axis_tdata),
		.cfg_we    (cfg_valid),
		.cfg_bit   (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: src/csort_dp.sv
// Datapath of the comb sort engine: element memory, count, gap, pass index,
// compare-swap logic and the output register. Depends on csort_pkg.
`default_nettype none
module csort_dp import csort_pkg::*; #(
	parameter int MAX_ITEMS    = 64,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire csort_cmd_t            cmd,
	output csort_sts_t                 sts,
	input  wire logic [VALUE_BITS-1:0] in_value,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_bit,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [VALUE_BITS-1:0]      out_value,
	output logic                       out_last
);

	localparam int CW    = $clog2(MAX_ITEMS + 1);
	localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int EW    = ELEMENT_BITS;
	localparam int YW    = CW + 4;
	localparam int SH    = YW + 4;
	localparam int RW    = SH - 3;
	localparam int RECIP = ((2 ** SH) + GAP_DEN - 1) / GAP_DEN;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

	logic [EW-1:0] mem [MAX_ITEMS];

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] gap_q;
	logic          swap_q;
	logic          signed_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] oidx_q;
	logic [EW-1:0] rd_a_q;
	logic [EW-1:0] rd_b_q;
	logic          out_valid_q;
	logic [EW-1:0] out_value_q;
	logic          out_last_q;

	logic [CW:0]      pair_sum;
	logic [AW-1:0]    addr_j;
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    wr_addr;
	logic [EW-1:0]    wr_data;
	logic             wr_en;
	logic [EW-1:0]    key_a;
	logic [EW-1:0]    key_b;
	logic [EW-1:0]    sign_flip;
	logic [YW-1:0]    gap_x10;
	logic [YW+RW-1:0] gap_prod;
	logic [YW-1:0]    gap_div;
	logic [YW-1:0]    gap_rule;
	logic             room;

	assign pair_sum  = (CW+1)'(idx_q) + (CW+1)'(gap_q);
	assign addr_j    = pair_sum[AW-1:0];
	assign addr_a    = cmd.rd_out ? oidx_q : idx_q;
	assign room      = cnt_q < CW'(MAX_ITEMS);
	assign sign_flip = {signed_q, {(EW-1){1'b0}}};
	assign key_a     = rd_a_q ^ sign_flip;
	assign key_b     = rd_b_q ^ sign_flip;

	assign gap_x10  = YW'(gap_q) * YW'(GAP_MUL);
	assign gap_prod = (YW+RW)'(gap_x10) * (YW+RW)'(RECIP_V);
	assign gap_div  = YW'(gap_prod[SH +: CW]);
	assign gap_rule = (gap_div == YW'(GAP_SKIP_LO) || gap_div == YW'(GAP_SKIP_HI))
		? YW'(GAP_ELEVEN) : gap_div;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_b_q;
		if (cmd.load && room) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[AW-1:0];
			wr_data = EW'(in_value);
		end else if (cmd.write_i) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = rd_b_q;
		end else if (cmd.write_j) begin
			wr_en   = 1'b1;
			wr_addr = addr_j;
			wr_data = rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_pair || cmd.rd_out) begin
			rd_a_q <= mem[addr_a];
		end
		if (cmd.rd_pair) begin
			rd_b_q <= mem[addr_j];
		end
		if (cmd.out_load) begin
			out_value_q <= rd_a_q;
			out_last_q  <= sts.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			gap_q       <= '0;
			swap_q      <= 1'b1;
			signed_q    <= 1'b0;
			idx_q       <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				signed_q <= cfg_bit;
			end
			if (cmd.load && room) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.init_sort) begin
				gap_q  <= cnt_q;
				swap_q <= 1'b1;
				oidx_q <= '0;
			end
			if (cmd.begin_pass) begin
				if (gap_q > CW'(1)) begin
					gap_q <= CW'(gap_rule);
				end
				swap_q <= 1'b0;
				idx_q  <= '0;
			end
			if (cmd.write_i) begin
				swap_q <= 1'b1;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				oidx_q      <= oidx_q + AW'(1);
				if (sts.out_last) begin
					cnt_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.gap_gt1  = gap_q > CW'(1);
	assign sts.swap     = swap_q;
	assign sts.pair_ok  = pair_sum < (CW+1)'(cnt_q);
	assign sts.greater  = key_a > key_b;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.out_last = CW'(oidx_q) == (cnt_q - CW'(1));

	assign out_valid = out_valid_q;
	assign out_value = VALUE_BITS'(out_value_q);
	assign out_last  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_ITEMS))
		else $error("element count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.write_i |-> sts.greater)
		else $error("swap issued on an ordered pair");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.rd_pair |-> sts.pair_ok)
		else $error("pair read past the list end");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && sts.out_last |=> cnt_q == '0)
		else $error("count not cleared after final result");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.begin_pass |=> !swap_q && gap_q != '0)
		else $error("pass started with bad gap or swap flag");

endmodule
`default_nettype wire

FILE: src/csort_ctrl.sv
// Controller of the comb sort engine: load, pass, compare-swap and output
// sequencing. Depends on csort_pkg; drives csort_dp through commands.
`default_nettype none
module csort_ctrl import csort_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_last,
	output logic            in_ready,
	input  wire csort_sts_t sts,
	output csort_cmd_t      cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_TEST  = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_WRJ   = 3'd5;
	localparam logic [2:0] ST_ORD   = 3'd6;
	localparam logic [2:0] ST_OPUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.init_sort = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.gap_gt1 || sts.swap) begin
					cmd.begin_pass = 1'b1;
					state_d        = ST_TEST;
				end else begin
					state_d = ST_ORD;
				end
			end
			ST_TEST: begin
				if (sts.pair_ok) begin
					cmd.rd_pair = 1'b1;
					state_d     = ST_CMP;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CMP: begin
				if (sts.greater) begin
					cmd.write_i = 1'b1;
					state_d     = ST_WRJ;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_TEST;
				end
			end
			ST_WRJ: begin
				cmd.write_j = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = ST_TEST;
			end
			ST_ORD: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_OPUT;
			end
			ST_OPUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sts.out_last ? ST_LOAD : ST_ORD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.write_i |=> cmd.write_j)
		else $error("swap left half done");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.rd_out |=> state_q == ST_OPUT)
		else $error("output read not followed by output load state");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> cmd.init_sort)
		else $error("closing request did not start the sort");

endmodule
`default_nettype wire

FILE: sim/sort_checker.sv
// Checker for the comb sort engine: watches the input, output and config channels,
// builds the sorted list that each closing request implies and compares the output.
// Depends on csort_pkg.
`timescale 1ns / 1ps
module sort_checker import csort_pkg::*; #(
	parameter int LIST_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [VALUE_BITS-1:0] s_axis_tdata,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [VALUE_BITS-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic                  cfg_data,
	output int                    mismatches,
	output int                    waiting
);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} sorted_item_t;

	sorted_item_t          sorted_q[$];
	logic [VALUE_BITS-1:0] list_buf[$];
	logic                  signed_mode = 1'b0;
	int                    errors = 0;

	function automatic logic [VALUE_BITS-1:0] order_of(input logic [VALUE_BITS-1:0] v);
		return signed_mode ? {~v[VALUE_BITS-1], v[VALUE_BITS-2:0]} : v;
	endfunction

	task automatic queue_sorted_list();
		logic [VALUE_BITS-1:0] held;
		sorted_item_t          item;
		int                    k;
		for (int i = 1; i < list_buf.size(); i++) begin
			held = list_buf[i];
			k = i;
			while (k > 0 && order_of(list_buf[k-1]) > order_of(held)) begin
				list_buf[k] = list_buf[k-1];
				k--;
			end
			list_buf[k] = held;
		end
		for (int i = 0; i < list_buf.size(); i++) begin
			item.value = list_buf[i];
			item.last  = (i == list_buf.size() - 1);
			sorted_q.push_back(item);
		end
		list_buf.delete();
	endtask

	always @(posedge clk) begin
		sorted_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				signed_mode = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (list_buf.size() < LIST_DEPTH)
					list_buf.push_back(s_axis_tdata);
				if (s_axis_tlast)
					queue_sorted_list();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_q.size() == 0) begin
					$display("%0t: result with nothing expected: actual %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = sorted_q.pop_front();
					if (m_axis_tdata !== want.value) begin
						$display("%0t: sorted_value mismatch: expected %h actual %h",
							$time, want.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: last_out mismatch: expected %b actual %b",
							$time, want.last, m_axis_tlast);
						errors++;
					end
				end
			end
		end
		mismatches <= errors;
		waiting    <= sorted_q.size();
	end

endmodule

FILE: sim/comb_sort_engine_unit_test.sv
// Testbench top for comb_sort_engine_unit: drives lists in bursts, stalls the output,
// sets the compare mode between lists and reports the verdict.
// Depends on csort_pkg, comb_sort_engine_unit and sort_checker.
`timescale 1ns / 1ps
module comb_sort_engine_unit_test import csort_pkg::*;;

	localparam int LIST_DEPTH = 64;
	localparam int RANDOM_ITEMS = 385;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [VALUE_BITS-1:0] s_axis_tdata;   // value[15:0]
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [VALUE_BITS-1:0] m_axis_tdata;   // sorted_value[15:0]
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_data;
	int                    mismatches;
	int                    waiting;

	int burst_left = 0;
	int rx_left    = 0;
	int rx_mode    = 0;

	always #10 clk = ~clk;

	comb_sort_engine_unit #(
		.MAX_ITEMS   (LIST_DEPTH),
		.ELEMENT_BITS(VALUE_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	sort_checker #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.waiting      (waiting)
	);

	// Receiver: stretches of full flow, light stalls and heavy stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	task automatic push_value(input logic [VALUE_BITS-1:0] v, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// Drop valid, drain every pending result, then let the engine go quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(input int style);
		case (style)
			1: return VALUE_BITS'($urandom_range(0, 7));
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h7FFF;
					default: return 16'h8000;
				endcase
			end
			3: return VALUE_BITS'(16'h7FF8 + $urandom_range(0, 15));
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	initial begin
		int items_sent;
		int roll;
		int len;
		int style;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		items_sent    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(1'b0);
		push_value(16'h1234, 1'b1);
		push_value(16'hFFFF, 1'b0);
		push_value(16'h0000, 1'b0);
		push_value(16'h8000, 1'b0);
		push_value(16'h7FFF, 1'b0);
		push_value(16'h0001, 1'b0);
		push_value(16'hFFFF, 1'b1);
		settle();
		write_mode(1'b1);
		push_value(16'hFFFF, 1'b0);
		push_value(16'h0000, 1'b0);
		push_value(16'h8000, 1'b0);
		push_value(16'h7FFF, 1'b0);
		push_value(16'h0001, 1'b0);
		push_value(16'hFFFF, 1'b1);
		push_value(16'h8000, 1'b1);
		push_value(16'h7FFF, 1'b0);
		push_value(16'h8000, 1'b1);
		settle();
		write_mode(1'b0);
		push_value(16'h0005, 1'b0);
		push_value(16'h0004, 1'b0);
		push_value(16'h0003, 1'b0);
		push_value(16'h0002, 1'b0);
		push_value(16'h0001, 1'b1);

		// Mostly short lists, some long, a few overfull closed by a dropped request.
		while (items_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				len = $urandom_range(1, 16);
			else if (roll < 95)
				len = $urandom_range(17, LIST_DEPTH);
			else
				len = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 8);
			style = $urandom_range(0, 3);
			for (int k = 0; k < len; k++)
				push_value(pick_value(style), (k == len - 1));
			items_sent += len;
			if ($urandom_range(0, 5) == 0) begin
				settle();
				write_mode(1'($urandom_range(0, 1)));
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
